[sv/esc_unesc_pkg.sv]
// types, constants and character helpers for the escape sequence unescaper
package esc_unesc_pkg;

    // longest \x run accepted before the string is flagged
    localparam int MAX_HEX_DIGITS = 8;
    // most result words that one source byte can cause
    localparam int MAX_RESULTS    = 11;

    // digit counter has to hold the longest run, hex or \U
    localparam int CNT_MAX = (MAX_HEX_DIGITS > 8) ? MAX_HEX_DIGITS : 8;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    // prefix of one step: backslash, letter and zeros of a null escape
    localparam int LEN_W   = $clog2(MAX_HEX_DIGITS + 5);
    // index of a result word within one step
    localparam int IDX_W   = $clog2(MAX_RESULTS);

    localparam logic [20:0] UNI_MAX   = 21'h10FFFF;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [7:0]  BYTE_MAX  = 8'hFF;

    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // escape decoder state
    typedef enum logic [2:0] {
        ESC_IDLE,
        ESC_BSL,
        ESC_OCT,
        ESC_HEX,
        ESC_U4,
        ESC_U8
    } t_mode;

    // closing word of a step, if any
    typedef enum logic [1:0] {
        ST_NONE,
        ST_END,
        ST_ERR
    } t_stat;

    function automatic logic is_oct(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h41) && (b <= 8'h46)) ||
               ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] low;
        low = b | 8'h20;
        if (b <= 8'h39) begin
            return 4'(b - 8'h30);
        end
        return 4'(low - 8'h61 + 8'd10);
    endfunction

endpackage

[sv/escape_sequence_unescaper.sv]
// streaming c-style escape decoder with utf-8 output for \u and \U
//
// Source bytes come in one word per cycle on i_valid/o_ready while o_ready is
// high, with i_in_last on the final byte of a string. Each accepted byte is
// decoded in the same cycle into a short run of result words (0 to 11) that is
// held in a run register and handed out one word per cycle on o_valid/i_ready
// while i_ready is high. A byte with no result leaves the input free; one with
// results holds the input until the last word of its run leaves, and the next
// byte is taken in that cycle. Plain text thus streams at one byte per clock
// while i_ready is high. A malformed string gives one word with o_decode_error
// set and the rest of the string is dropped up to its last byte, which gives a
// closing word with o_string_end and o_decode_error. i_cfg_wdata written with
// i_cfg_we sets keep_null_escapes; write it only while the block is idle.
module escape_sequence_unescaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_run_last,
    output logic       o_string_end,
    output logic       o_decode_error
);

    // decoder state
    esc_unesc_pkg::t_mode              r_mode, n_mode;
    logic [20:0]                       r_code, n_code;
    logic [esc_unesc_pkg::CNT_W-1:0]   r_cnt,  n_cnt;
    logic                              r_upper, n_upper;
    logic                              r_drop, n_drop;
    logic                              r_keep;

    // run register: the result words of one source byte
    logic                              r_busy;
    logic [esc_unesc_pkg::IDX_W-1:0]   r_idx;
    logic [esc_unesc_pkg::IDX_W-1:0]   r_lastidx, n_lastidx;
    logic [7:0]                        r_pre_b [4];
    logic [7:0]                        n_pre_b [4];
    logic [esc_unesc_pkg::LEN_W-1:0]   r_pre_len, n_pre_len;
    logic                              r_plain, n_plain;
    logic [7:0]                        r_plain_b;
    esc_unesc_pkg::t_stat              r_stat, n_stat;
    logic                              r_last;
    logic [7:0]                        n_total;

    logic in_acc;
    logic out_take;

    // one source byte decoded into prefix, plain byte and closing word
    always_comb begin
        logic                             ok;
        logic                             end_ok;
        logic                             do_flush;
        logic [8:0]                       fl_val;
        logic [7:0]                       fl_letter;
        logic [esc_unesc_pkg::CNT_W-1:0]  fl_zeros;
        logic                             do_uni;
        logic [20:0]                      u_val;
        logic [7:0]                       u_letter;
        logic [esc_unesc_pkg::CNT_W-1:0]  u_zeros;
        logic                             null_hit;
        logic [7:0]                       nl_letter;
        logic [esc_unesc_pkg::CNT_W-1:0]  nl_zeros;
        logic [24:0]                      shifted;
        logic [23:0]                      oct_acc;
        logic [esc_unesc_pkg::CNT_W-1:0]  cnt_inc;

        n_mode    = r_mode;
        n_code    = r_code;
        n_cnt     = r_cnt;
        n_upper   = r_upper;
        n_drop    = r_drop;
        n_pre_b   = '{default: esc_unesc_pkg::CH_ZERO};
        n_pre_len = '0;
        n_plain   = 1'b0;
        n_stat    = esc_unesc_pkg::ST_NONE;
        ok        = 1'b1;
        end_ok    = 1'b1;
        do_flush  = 1'b0;
        fl_val    = '0;
        fl_letter = '0;
        fl_zeros  = '0;
        do_uni    = 1'b0;
        u_val     = '0;
        u_letter  = '0;
        u_zeros   = '0;
        null_hit  = 1'b0;
        nl_letter = '0;
        nl_zeros  = '0;
        shifted   = {r_code, esc_unesc_pkg::hex_val(i_in_byte)};
        oct_acc   = {r_code, 3'(i_in_byte - 8'h30)};
        cnt_inc   = esc_unesc_pkg::CNT_W'(r_cnt + 1'b1);

        if (r_drop) begin
            // skip to the last byte of a bad string
            if (i_in_last) begin
                n_drop  = 1'b0;
                n_mode  = esc_unesc_pkg::ESC_IDLE;
                n_code  = '0;
                n_cnt   = '0;
                n_upper = 1'b0;
                n_stat  = esc_unesc_pkg::ST_ERR;
            end
        end else begin
            // byte decode by escape state
            case (r_mode)
                esc_unesc_pkg::ESC_BSL: begin
                    n_mode = esc_unesc_pkg::ESC_IDLE;
                    n_pre_len = esc_unesc_pkg::LEN_W'(1);
                    case (i_in_byte)
                        "a":  n_pre_b[0] = 8'h07;
                        "b":  n_pre_b[0] = 8'h08;
                        "f":  n_pre_b[0] = 8'h0C;
                        "n":  n_pre_b[0] = 8'h0A;
                        "r":  n_pre_b[0] = 8'h0D;
                        "t":  n_pre_b[0] = 8'h09;
                        "v":  n_pre_b[0] = 8'h0B;
                        "\\", "?", "'", "\"": n_pre_b[0] = i_in_byte;
                        "x", "X": begin
                            n_pre_len = '0;
                            n_upper   = (i_in_byte == "X");
                            n_mode    = esc_unesc_pkg::ESC_HEX;
                            n_code    = '0;
                            n_cnt     = '0;
                        end
                        "u": begin
                            n_pre_len = '0;
                            n_mode    = esc_unesc_pkg::ESC_U4;
                            n_code    = '0;
                            n_cnt     = '0;
                        end
                        "U": begin
                            n_pre_len = '0;
                            n_mode    = esc_unesc_pkg::ESC_U8;
                            n_code    = '0;
                            n_cnt     = '0;
                        end
                        default: begin
                            n_pre_len = '0;
                            if (esc_unesc_pkg::is_oct(i_in_byte)) begin
                                n_mode = esc_unesc_pkg::ESC_OCT;
                                n_code = 21'(i_in_byte - 8'h30);
                                n_cnt  = esc_unesc_pkg::CNT_W'(1);
                            end else begin
                                ok = 1'b0;
                            end
                        end
                    endcase
                end
                esc_unesc_pkg::ESC_OCT: begin
                    if (esc_unesc_pkg::is_oct(i_in_byte)) begin
                        n_code = oct_acc[20:0];
                        n_cnt  = cnt_inc;
                        if (cnt_inc >= esc_unesc_pkg::CNT_W'(3)) begin
                            n_mode    = esc_unesc_pkg::ESC_IDLE;
                            do_flush  = 1'b1;
                            fl_val    = 9'(oct_acc);
                            fl_zeros  = cnt_inc;
                            if (oct_acc > 24'(esc_unesc_pkg::BYTE_MAX)) begin
                                ok = 1'b0;
                            end
                        end
                    end else begin
                        n_mode   = esc_unesc_pkg::ESC_IDLE;
                        do_flush = 1'b1;
                        fl_val   = 9'(r_code);
                        fl_zeros = r_cnt;
                        if (r_code > 21'(esc_unesc_pkg::BYTE_MAX)) begin
                            ok = 1'b0;
                        end else if (i_in_byte == esc_unesc_pkg::CH_BSL) begin
                            n_mode = esc_unesc_pkg::ESC_BSL;
                        end else begin
                            n_plain = 1'b1;
                        end
                    end
                end
                esc_unesc_pkg::ESC_HEX: begin
                    if (esc_unesc_pkg::is_hex(i_in_byte)) begin
                        if (r_cnt >= esc_unesc_pkg::CNT_W'(esc_unesc_pkg::MAX_HEX_DIGITS)) begin
                            ok = 1'b0;
                        end else begin
                            n_code = shifted[20:0];
                            n_cnt  = cnt_inc;
                            ok     = (shifted <= 25'(esc_unesc_pkg::BYTE_MAX));
                        end
                    end else if (r_cnt == '0) begin
                        ok = 1'b0;
                    end else begin
                        n_mode    = esc_unesc_pkg::ESC_IDLE;
                        do_flush  = 1'b1;
                        fl_val    = 9'(r_code);
                        fl_letter = r_upper ? "X" : "x";
                        fl_zeros  = r_cnt;
                        if (i_in_byte == esc_unesc_pkg::CH_BSL) begin
                            n_mode = esc_unesc_pkg::ESC_BSL;
                        end else begin
                            n_plain = 1'b1;
                        end
                    end
                end
                esc_unesc_pkg::ESC_U4, esc_unesc_pkg::ESC_U8: begin
                    if (!esc_unesc_pkg::is_hex(i_in_byte)) begin
                        ok = 1'b0;
                    end else if (shifted > 25'(esc_unesc_pkg::UNI_MAX)) begin
                        ok = 1'b0;
                    end else begin
                        n_code = shifted[20:0];
                        n_cnt  = cnt_inc;
                        if (r_mode == esc_unesc_pkg::ESC_U4 &&
                            cnt_inc >= esc_unesc_pkg::CNT_W'(4)) begin
                            n_mode   = esc_unesc_pkg::ESC_IDLE;
                            do_uni   = 1'b1;
                            u_val    = shifted[20:0];
                            u_letter = "u";
                            u_zeros  = esc_unesc_pkg::CNT_W'(4);
                        end else if (r_mode == esc_unesc_pkg::ESC_U8 &&
                                     cnt_inc >= esc_unesc_pkg::CNT_W'(8)) begin
                            n_mode   = esc_unesc_pkg::ESC_IDLE;
                            do_uni   = 1'b1;
                            u_val    = shifted[20:0];
                            u_letter = "U";
                            u_zeros  = esc_unesc_pkg::CNT_W'(8);
                        end
                    end
                end
                default: begin
                    if (i_in_byte == esc_unesc_pkg::CH_BSL) begin
                        n_mode = esc_unesc_pkg::ESC_BSL;
                    end else begin
                        n_plain = 1'b1;
                    end
                end
            endcase

            // an escape still open at the end of the string; words already
            // decoded from this byte still go out ahead of the error word
            if (ok && i_in_last) begin
                case (n_mode)
                    esc_unesc_pkg::ESC_IDLE: ;
                    esc_unesc_pkg::ESC_OCT: begin
                        if (n_code > 21'(esc_unesc_pkg::BYTE_MAX)) begin
                            end_ok = 1'b0;
                        end else begin
                            do_flush = 1'b1;
                            fl_val   = 9'(n_code);
                            fl_zeros = n_cnt;
                        end
                    end
                    esc_unesc_pkg::ESC_HEX: begin
                        if (n_cnt == '0) begin
                            end_ok = 1'b0;
                        end else begin
                            do_flush  = 1'b1;
                            fl_val    = 9'(n_code);
                            fl_letter = n_upper ? "X" : "x";
                            fl_zeros  = n_cnt;
                        end
                    end
                    default: end_ok = 1'b0;
                endcase
            end

            // value of a finished octal or hex run
            if (do_flush && ok) begin
                if (fl_val == '0 && r_keep) begin
                    null_hit  = 1'b1;
                    nl_letter = fl_letter;
                    nl_zeros  = fl_zeros;
                end else begin
                    n_pre_b[0] = fl_val[7:0];
                    n_pre_len  = esc_unesc_pkg::LEN_W'(1);
                end
            end

            // utf-8 encoding of a finished \u or \U
            if (do_uni && ok) begin
                if (u_val == '0 && r_keep) begin
                    null_hit  = 1'b1;
                    nl_letter = u_letter;
                    nl_zeros  = u_zeros;
                end else if (u_val >= esc_unesc_pkg::SURR_LO &&
                             u_val <= esc_unesc_pkg::SURR_HI) begin
                    ok = 1'b0;
                end else if (u_val < 21'h80) begin
                    n_pre_b[0] = u_val[7:0];
                    n_pre_len  = esc_unesc_pkg::LEN_W'(1);
                end else if (u_val < 21'h800) begin
                    n_pre_b[0] = {3'b110, u_val[10:6]};
                    n_pre_b[1] = {2'b10, u_val[5:0]};
                    n_pre_len  = esc_unesc_pkg::LEN_W'(2);
                end else if (u_val < 21'h10000) begin
                    n_pre_b[0] = {4'b1110, u_val[15:12]};
                    n_pre_b[1] = {2'b10, u_val[11:6]};
                    n_pre_b[2] = {2'b10, u_val[5:0]};
                    n_pre_len  = esc_unesc_pkg::LEN_W'(3);
                end else begin
                    n_pre_b[0] = {5'b11110, u_val[20:18]};
                    n_pre_b[1] = {2'b10, u_val[17:12]};
                    n_pre_b[2] = {2'b10, u_val[11:6]};
                    n_pre_b[3] = {2'b10, u_val[5:0]};
                    n_pre_len  = esc_unesc_pkg::LEN_W'(4);
                end
            end

            // null escape given back as its own text
            if (null_hit) begin
                n_pre_b[0] = esc_unesc_pkg::CH_BSL;
                n_pre_b[1] = (nl_letter != '0) ? nl_letter : esc_unesc_pkg::CH_ZERO;
                n_pre_len  = esc_unesc_pkg::LEN_W'(1 + (nl_letter != '0) + nl_zeros);
            end

            // closing word and state clear
            if (!ok || !end_ok) begin
                n_stat  = esc_unesc_pkg::ST_ERR;
                n_mode  = esc_unesc_pkg::ESC_IDLE;
                n_code  = '0;
                n_cnt   = '0;
                n_upper = 1'b0;
                n_drop  = !i_in_last;
            end else if (i_in_last) begin
                if (n_pre_len == '0 && !n_plain) begin
                    n_stat = esc_unesc_pkg::ST_END;
                end
                n_mode  = esc_unesc_pkg::ESC_IDLE;
                n_code  = '0;
                n_cnt   = '0;
                n_upper = 1'b0;
            end
        end

        // number of words in the run, capped
        n_total = 8'(n_pre_len) + 8'(n_plain) + 8'(n_stat != esc_unesc_pkg::ST_NONE);
        if (n_total >= 8'(esc_unesc_pkg::MAX_RESULTS)) begin
            n_lastidx = esc_unesc_pkg::IDX_W'(esc_unesc_pkg::MAX_RESULTS - 1);
        end else begin
            n_lastidx = esc_unesc_pkg::IDX_W'(n_total - 8'd1);
        end
    end

    // handshakes
    assign out_take = r_busy && i_ready;
    assign o_ready  = !r_busy || (i_ready && (r_idx == r_lastidx));
    assign in_acc   = i_valid && o_ready;

    // decoder state and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= esc_unesc_pkg::ESC_IDLE;
            r_code  <= '0;
            r_cnt   <= '0;
            r_upper <= 1'b0;
            r_drop  <= 1'b0;
            r_keep  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_mode  <= n_mode;
                r_code  <= n_code;
                r_cnt   <= n_cnt;
                r_upper <= n_upper;
                r_drop  <= n_drop;
            end
        end
    end

    // run register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (out_take) begin
                if (r_idx == r_lastidx) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= esc_unesc_pkg::IDX_W'(r_idx + 1'b1);
                end
            end
            if (in_acc && n_total != 8'd0) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
        end
    end

    // run register payload
    always_ff @(posedge i_clk) begin
        if (in_acc && n_total != 8'd0) begin
            r_pre_b   <= n_pre_b;
            r_pre_len <= n_pre_len;
            r_plain   <= n_plain;
            r_plain_b <= i_in_byte;
            r_stat    <= n_stat;
            r_last    <= i_in_last;
            r_lastidx <= n_lastidx;
        end
    end

    // pick the current word of the run
    always_comb begin
        o_out_byte     = '0;
        o_out_valid    = 1'b0;
        o_decode_error = 1'b0;
        if (8'(r_idx) < 8'(r_pre_len)) begin
            o_out_valid = 1'b1;
            o_out_byte  = (8'(r_idx) < 8'd4) ? r_pre_b[r_idx[1:0]] : esc_unesc_pkg::CH_ZERO;
        end else if (8'(r_idx) == 8'(r_pre_len) && r_plain) begin
            o_out_valid = 1'b1;
            o_out_byte  = r_plain_b;
        end else begin
            o_decode_error = (r_stat == esc_unesc_pkg::ST_ERR);
        end
    end

    assign o_valid      = r_busy;
    assign o_run_last   = (r_idx == r_lastidx);
    assign o_string_end = (r_idx == r_lastidx) && r_last;

endmodule
